### hdl/dct_pkg.sv
// Shared types and constants of the droplet contamination tracker.
package dct_pkg;

   localparam logic OP_RECORD   = 1'b0;
   localparam logic OP_QUERY    = 1'b1;
   localparam logic KIND_WASH   = 1'b0;
   localparam logic KIND_ANSWER = 1'b1;

   // Width of the effective grid limits, wide enough for a count of 64.
   localparam int LIM_W = 7;

   // Result queue depth and the width of its fill count.
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_CW    = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic [LIM_W-1:0] eff_rows;
      logic [LIM_W-1:0] eff_cols;
   } limits_type;

   typedef struct packed {
      logic       op;
      logic       in_grid;
      logic [7:0] step;
      logic [3:0] row;
      logic [3:0] col;
      logic [7:0] dtype;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_stat_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] wash_row;
      logic [3:0] wash_col;
      logic [7:0] wash_from;
      logic [7:0] wash_to;
      logic       reachable;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type rsp;
   } rsp_push_type;

endpackage

### hdl/dct_front.sv
// Front part: accepts request beats, classifies them and queues them for the back part.
module dct_front import dct_pkg::*; #(
   parameter int MAX_STEPS = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  logic          req_operation,
   input  logic [7:0]    req_step,
   input  logic [3:0]    req_row,
   input  logic [3:0]    req_col,
   input  logic [7:0]    req_droplet_type,
   input  limits_type    limits,
   input  back_stat_type stat,
   output cmd_head_type  head
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   cmd_type          cmd_new;
   logic             accept;

   // A cell is inside the chip when both coordinates are below the limits
   // and the step lies within the bitmap.
   always_comb begin
      cmd_new.op      = req_operation;
      cmd_new.step    = req_step;
      cmd_new.row     = req_row;
      cmd_new.col     = req_col;
      cmd_new.dtype   = req_droplet_type;
      cmd_new.in_grid = (LIM_W'(req_row) < limits.eff_rows) &&
                        (LIM_W'(req_col) < limits.eff_cols) &&
                        (13'(req_step) < 13'(MAX_STEPS));
   end

   assign full   = (count_ff == CW'(DEPTH)) || stat.clearing;
   assign accept = push && !full;

   always_comb begin
      wr_ptr_in = accept   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = stat.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = CW'(count_ff + CW'(accept) - CW'(stat.pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entries_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

endmodule

### hdl/dct_back.sv
// Back part: reachability bitmap, cell store, item sequencer and the clearing pass.
module dct_back import dct_pkg::*; #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int MAX_STEPS = 256,
   parameter int TYPE_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  limits_type         limits,
   input  cmd_head_type       head,
   output back_stat_type      stat,
   input  logic [RSPQ_CW-1:0] rspq_count,
   output rsp_push_type       out
);

   localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int STEP_AW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int TYPE_W   = (TYPE_BITS < 8) ? TYPE_BITS : 8;
   localparam int REACH_AW = STEP_AW + ROW_AW;
   localparam int CELL_AW  = ROW_AW + COL_AW;
   localparam int CLR_AW   = (REACH_AW > CELL_AW) ? REACH_AW : CELL_AW;
   localparam int CELL_W   = 1 + TYPE_W + 8;

   logic [MAX_COLS-1:0] reach_mem [2**REACH_AW];
   logic [CELL_W-1:0]   cell_mem  [2**CELL_AW];

   logic                busy_ff, busy_in;
   logic [1:0]          phase_ff, phase_in;
   cmd_type             cmd_ff, cmd_in;
   logic                clearing_ff, clearing_in;
   logic [CLR_AW-1:0]   clr_ff, clr_in;
   logic [MAX_COLS-1:0] reach_q_ff;
   logic [CELL_W-1:0]   cell_q_ff;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [MAX_COLS-1:0] fwd_data_ff;

   logic                last, start, room, first;
   logic                is_query, do_wash;
   logic [1:0]          rd_k, wr_k;
   cmd_type             rd_cmd;
   logic [REACH_AW-1:0] rd_addr, reach_wa;
   logic                reach_we;
   logic [MAX_COLS-1:0] reach_wd, word;
   logic                cell_we;
   logic [CELL_AW-1:0]  cell_ra, cell_wa;
   logic [CELL_W-1:0]   cell_wd;

   function automatic logic [LIM_W-1:0] row_of(input cmd_type c, input logic [1:0] k);
      return LIM_W'(c.row) + LIM_W'(k) - LIM_W'(1);
   endfunction

   function automatic logic [REACH_AW-1:0] row_addr(input cmd_type c, input logic [1:0] k);
      logic [LIM_W-1:0] r;
      r = row_of(c, k);
      return {STEP_AW'(c.step), ROW_AW'(r)};
   endfunction

   // Columns col-1, col and col+1 that lie inside the chip.
   function automatic logic [MAX_COLS-1:0] col_mask(input logic [3:0] col,
                                                    input logic [LIM_W-1:0] ncols);
      logic [MAX_COLS-1:0] m;
      logic [LIM_W-1:0]    jj;
      logic [LIM_W-1:0]    c7;
      c7 = LIM_W'(col);
      for (int j = 0; j < MAX_COLS; j++) begin
         jj   = LIM_W'(j);
         m[j] = (jj < ncols) && ((jj == c7) || (jj + LIM_W'(1) == c7) ||
                                 (jj == c7 + LIM_W'(1)));
      end
      return m;
   endfunction

   assign is_query = (cmd_ff.op == OP_QUERY);
   assign first    = busy_ff && (phase_ff == 2'd1);
   assign last     = busy_ff && ((first && (is_query || !cmd_ff.in_grid)) ||
                                 (phase_ff == 2'd3));

   // The word just read, or the word written in the same cycle as its read.
   assign word = fwd_hit_ff ? fwd_data_ff : reach_q_ff;

   assign do_wash = !is_query && cmd_ff.in_grid && cell_q_ff[CELL_W-1] &&
                    (cell_q_ff[CELL_W-2:8] != TYPE_W'(cmd_ff.dtype));

   always_comb begin
      out.push          = first && (is_query || do_wash);
      out.rsp.kind      = is_query ? KIND_ANSWER : KIND_WASH;
      out.rsp.wash_row  = is_query ? 4'd0 : cmd_ff.row;
      out.rsp.wash_col  = is_query ? 4'd0 : cmd_ff.col;
      out.rsp.wash_from = is_query ? 8'd0 : cmd_ff.step + 8'd1;
      out.rsp.wash_to   = is_query ? 8'd0 : cell_q_ff[7:0] - 8'd1;
      out.rsp.reachable = is_query && cmd_ff.in_grid && word[COL_AW'(cmd_ff.col)];
   end

   // A new item starts only when its result is sure to find room.
   assign room  = (RSPQ_CW'(rspq_count) + RSPQ_CW'(out.push)) < RSPQ_CW'(RSPQ_DEPTH);
   assign start = !clearing_ff && (!busy_ff || last) && head.valid && room;

   assign stat.pop      = start;
   assign stat.clearing = clearing_ff;

   always_comb begin
      rd_cmd  = start ? head.cmd : cmd_ff;
      rd_k    = start ? ((head.cmd.op == OP_QUERY) ? 2'd1 : 2'd0) : phase_ff;
      rd_addr = row_addr(rd_cmd, rd_k);
      wr_k    = phase_ff - 2'd1;
      cell_ra = {ROW_AW'(head.cmd.row), COL_AW'(head.cmd.col)};

      if (clearing_ff) begin
         reach_we = 1'b1;
         reach_wa = REACH_AW'(clr_ff);
         reach_wd = '1;
         cell_we  = 1'b1;
         cell_wa  = CELL_AW'(clr_ff);
         cell_wd  = '0;
      end else begin
         reach_we = busy_ff && !is_query && cmd_ff.in_grid &&
                    (row_of(cmd_ff, wr_k) < limits.eff_rows);
         reach_wa = row_addr(cmd_ff, wr_k);
         reach_wd = word & ~col_mask(cmd_ff.col, limits.eff_cols);
         cell_we  = first && !is_query && cmd_ff.in_grid;
         cell_wa  = {ROW_AW'(cmd_ff.row), COL_AW'(cmd_ff.col)};
         cell_wd  = {1'b1, TYPE_W'(cmd_ff.dtype), cmd_ff.step};
      end

      fwd_hit_in = reach_we && (reach_wa == rd_addr);
   end

   always_comb begin
      busy_in     = busy_ff;
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 2'd1;
         cmd_in   = head.cmd;
      end else if (last) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         phase_ff    <= 2'd0;
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         phase_ff    <= phase_in;
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      fwd_data_ff <= reach_wd;
   end

   always_ff @(posedge clock) begin
      if (reach_we) begin
         reach_mem[reach_wa] <= reach_wd;
      end
      reach_q_ff <= reach_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      cell_q_ff <= cell_mem[cell_ra];
   end

endmodule

### hdl/dct_rsp_queue.sv
// Result queue that holds finished results until the consumer pops them.
module dct_rsp_queue import dct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  rsp_push_type       in,
   output logic [RSPQ_CW-1:0] count,
   output logic               empty,
   input  logic               pop,
   output rsp_type            head
);

   localparam int PW = $clog2(RSPQ_DEPTH);

   rsp_type            entries_ff [RSPQ_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CW-1:0] count_ff, count_in;
   logic               take;

   assign empty = (count_ff == '0);
   assign take  = pop && !empty;
   assign count = count_ff;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = in.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take    ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = RSPQ_CW'(count_ff + RSPQ_CW'(in.push) - RSPQ_CW'(take));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in.push) begin
         entries_ff[wr_ptr_ff] <= in.rsp;
      end
   end

endmodule

### hdl/droplet_contamination_tracker.sv
// A query or a washing record is queued in the front part, taken into the back part's command
// register, pushed into the result queue and then shown on the result ports. A record does one
// bitmap read-modify-write per neighbour row word, a query or an off-chip record does none; the
// back part takes a new item only as it finishes the last and waits while the result queue has
// no room. Synchronous reset sets 16 rows and 16 columns; a clearing pass over 2**max(step+row,
// row+col address bits) entries sets the bitmap to ones, empties the cell store, full high.
module droplet_contamination_tracker import dct_pkg::*; #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int MAX_STEPS = 256,
   parameter int TYPE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        push,
   output logic        full,
   input  logic        req_operation,
   input  logic [7:0]  req_step,
   input  logic [3:0]  req_row,
   input  logic [3:0]  req_col,
   input  logic [7:0]  req_droplet_type,
   // Result channel.
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [3:0]  rsp_wash_row,
   output logic [3:0]  rsp_wash_col,
   output logic [7:0]  rsp_wash_from,
   output logic [7:0]  rsp_wash_to,
   output logic        rsp_reachable,
   // Register port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Register indexes, taken from byte address bit two.
   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   logic [4:0]         rows_ff, rows_in;
   logic [4:0]         cols_ff, cols_in;
   logic               csr_write;
   limits_type         limits;
   cmd_head_type       head;
   back_stat_type      stat;
   rsp_push_type       rsp_push;
   logic [RSPQ_CW-1:0] rspq_count;
   rsp_type            rsp_head;

   // The register port never waits, so a write lands in its access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_ROWS: rows_in = pwdata[4:0];
            REG_COLS: cols_in = pwdata[4:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 5'd16;
         cols_ff <= 5'd16;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_ff) : 32'(rows_ff);

   // The grid in use is the register value, capped by the size that was built.
   always_comb begin
      limits.eff_rows = (LIM_W'(rows_ff) < LIM_W'(MAX_ROWS)) ? LIM_W'(rows_ff)
                                                            : LIM_W'(MAX_ROWS);
      limits.eff_cols = (LIM_W'(cols_ff) < LIM_W'(MAX_COLS)) ? LIM_W'(cols_ff)
                                                            : LIM_W'(MAX_COLS);
   end

   // The front part classifies each beat and holds it in a short queue, so the
   // producer keeps pushing while the back part works through a record.
   dct_front #(
      .MAX_STEPS (MAX_STEPS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_operation    (req_operation),
      .req_step         (req_step),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_droplet_type (req_droplet_type),
      .limits           (limits),
      .stat             (stat),
      .head             (head)
   );

   // The back part owns both stores. A record clears up to three bitmap words
   // and updates the cell entry; a query reads one bit.
   dct_back #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_STEPS (MAX_STEPS),
      .TYPE_BITS (TYPE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .limits     (limits),
      .head       (head),
      .stat       (stat),
      .rspq_count (rspq_count),
      .out        (rsp_push)
   );

   // Results wait here, so a stalled consumer never holds up the back part
   // until the queue is full.
   dct_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .in    (rsp_push),
      .count (rspq_count),
      .empty (empty),
      .pop   (pop),
      .head  (rsp_head)
   );

   assign rsp_kind      = rsp_head.kind;
   assign rsp_wash_row  = rsp_head.wash_row;
   assign rsp_wash_col  = rsp_head.wash_col;
   assign rsp_wash_from = rsp_head.wash_from;
   assign rsp_wash_to   = rsp_head.wash_to;
   assign rsp_reachable = rsp_head.reachable;

endmodule
